>>> hw/rtl/bol_pkg.sv
// Package for the bounded ordered list: sizes, command and status codes, and the
// control struct handed from the list controller to each storage cell.
// Depends on nothing; used by every module of the block.
`default_nettype none
package bol_pkg;

   localparam int unsigned CAPACITY_ENTRIES = 16;
   localparam int unsigned ENTRY_WIDTH      = 32;

   localparam int unsigned CMD_W       = 2;
   localparam int unsigned INDEX_W     = 4;
   localparam int unsigned ITEM_W      = 32;
   localparam int unsigned STATUS_W    = 2;
   localparam int unsigned COUNT_OUT_W = 5;

   localparam int unsigned COUNT_W = $clog2(CAPACITY_ENTRIES + 1);
   localparam int unsigned CMP_W   = (COUNT_W > INDEX_W) ? COUNT_W : INDEX_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND = 2'd0,
      CMD_READ   = 2'd1,
      CMD_REMOVE = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_BAD_INDEX = 2'd3
   } status_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic read_sel;
      logic last_sel;
   } cell_ctrl_type;

endpackage
`default_nettype wire

>>> hw/rtl/bol_cell.sv
// One storage cell of the list: holds a single entry, loads an appended item or
// takes its upper neighbour's entry on a removal, and adds itself to the read chains.
// Depends on bol_pkg.
`default_nettype none
module bol_cell (
   input  wire logic                             clock,
   input  wire bol_pkg::cell_ctrl_type           ctrl,
   input  wire logic [bol_pkg::ENTRY_WIDTH-1:0]  item,
   input  wire logic [bol_pkg::ENTRY_WIDTH-1:0]  upper_value,
   input  wire logic [bol_pkg::ENTRY_WIDTH-1:0]  read_chain_in,
   input  wire logic [bol_pkg::ENTRY_WIDTH-1:0]  last_chain_in,
   output logic      [bol_pkg::ENTRY_WIDTH-1:0]  value,
   output logic      [bol_pkg::ENTRY_WIDTH-1:0]  read_chain_out,
   output logic      [bol_pkg::ENTRY_WIDTH-1:0]  last_chain_out
);

   logic [bol_pkg::ENTRY_WIDTH-1:0] value_ff;
   logic [bol_pkg::ENTRY_WIDTH-1:0] value_in;

   always_comb begin
      priority if (ctrl.load) begin
         value_in = item;
      end else if (ctrl.shift) begin
         value_in = upper_value;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value          = value_ff;
   assign read_chain_out = read_chain_in | (ctrl.read_sel ? value_ff : '0);
   assign last_chain_out = last_chain_in | (ctrl.last_sel ? value_ff : '0);

endmodule
`default_nettype wire

>>> hw/rtl/bounded_ordered_list_core.sv
// Top level of the bounded ordered list: command decode, entry count, the row of
// storage cells and the registered response.
// Depends on bol_pkg and bol_cell.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | cmd, index, item
//   rsp     | out       | rsp_valid / rsp_stall | status, read_value, first_value,
//           |           |                       | last_value, entry_count, is_empty
//
// A request is applied to the cells at the edge that accepts it; the response is
// formed from the updated cells when the request leaves the single pending stage
// ahead of the response register; no request is taken while one is pending.
// Reset clears the count and the handshake state; entries are not cleared.
// A stalled response holds the pending stage, which in turn stalls requests.
`default_nettype none
module bounded_ordered_list_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [bol_pkg::CMD_W-1:0]          req_cmd,
   input  wire logic [bol_pkg::INDEX_W-1:0]        req_index,
   input  wire logic [bol_pkg::ITEM_W-1:0]         req_item,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic      [bol_pkg::STATUS_W-1:0]       rsp_status,
   output logic      [bol_pkg::ITEM_W-1:0]         rsp_read_value,
   output logic      [bol_pkg::ITEM_W-1:0]         rsp_first_value,
   output logic      [bol_pkg::ITEM_W-1:0]         rsp_last_value,
   output logic      [bol_pkg::COUNT_OUT_W-1:0]    rsp_entry_count,
   output logic                                    rsp_is_empty
);

   localparam int unsigned N = bol_pkg::CAPACITY_ENTRIES;
   localparam int unsigned W = bol_pkg::ENTRY_WIDTH;

   logic [bol_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic                          pend_valid_ff, pend_valid_in;
   bol_pkg::status_type           pend_status_ff, pend_status_in;
   logic                          pend_read_ff, pend_read_in;
   logic [bol_pkg::INDEX_W-1:0]   pend_index_ff, pend_index_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [bol_pkg::STATUS_W-1:0]  rsp_status_ff;
   logic [bol_pkg::ITEM_W-1:0]    rsp_read_ff, rsp_first_ff, rsp_last_ff;
   logic [bol_pkg::COUNT_OUT_W-1:0] rsp_count_ff;
   logic                          rsp_empty_ff;

   logic                          accept;
   logic                          transfer;
   logic                          append_ok;
   logic                          remove_ok;
   bol_pkg::status_type           status;
   logic [bol_pkg::CMP_W-1:0]     idx_cmp;
   logic [bol_pkg::CMP_W-1:0]     cnt_cmp;
   logic [bol_pkg::CMP_W-1:0]     pend_idx_cmp;
   logic [W-1:0]                  item_word;

   bol_pkg::cell_ctrl_type        ctrl [N];
   logic [W-1:0]                  value [N];
   logic [W-1:0]                  upper [N];
   logic [W-1:0]                  read_chain [N+1];
   logic [W-1:0]                  last_chain [N+1];

   assign accept       = req_valid && !pend_valid_ff;
   assign transfer     = pend_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign idx_cmp      = bol_pkg::CMP_W'(req_index);
   assign cnt_cmp      = bol_pkg::CMP_W'(count_ff);
   assign pend_idx_cmp = bol_pkg::CMP_W'(pend_index_ff);
   assign item_word    = W'(req_item);

   always_comb begin
      status    = bol_pkg::ST_OK;
      append_ok = 1'b0;
      remove_ok = 1'b0;
      unique case (req_cmd)
         bol_pkg::CMD_APPEND: begin
            if (count_ff >= bol_pkg::COUNT_W'(N)) begin
               status = bol_pkg::ST_FULL;
            end else begin
               append_ok = 1'b1;
            end
         end
         bol_pkg::CMD_READ: begin
            if (idx_cmp >= cnt_cmp) begin
               status = bol_pkg::ST_BAD_INDEX;
            end
         end
         bol_pkg::CMD_REMOVE: begin
            if (count_ff == '0) begin
               status = bol_pkg::ST_EMPTY;
            end else if (idx_cmp >= cnt_cmp) begin
               status = bol_pkg::ST_BAD_INDEX;
            end else begin
               remove_ok = 1'b1;
            end
         end
         default: begin
            status = bol_pkg::ST_OK;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < N; i++) begin
         ctrl[i].load     = accept && append_ok && (cnt_cmp == bol_pkg::CMP_W'(i));
         ctrl[i].shift    = accept && remove_ok && (idx_cmp <= bol_pkg::CMP_W'(i))
                            && (bol_pkg::CMP_W'(i + 1) < cnt_cmp);
         ctrl[i].read_sel = pend_read_ff && (pend_idx_cmp == bol_pkg::CMP_W'(i));
         ctrl[i].last_sel = (cnt_cmp == bol_pkg::CMP_W'(i + 1));
      end
   end

   assign read_chain[N] = '0;
   assign last_chain[N] = '0;

   for (genvar g = 0; g < N; g++) begin : g_cell
      if (g == N - 1) begin : g_top
         assign upper[g] = '0;
      end else begin : g_mid
         assign upper[g] = value[g+1];
      end
      bol_cell u_cell (
         .clock          (clock),
         .ctrl           (ctrl[g]),
         .item           (item_word),
         .upper_value    (upper[g]),
         .read_chain_in  (read_chain[g+1]),
         .last_chain_in  (last_chain[g+1]),
         .value          (value[g]),
         .read_chain_out (read_chain[g]),
         .last_chain_out (last_chain[g])
      );
   end

   always_comb begin
      count_in       = count_ff;
      pend_valid_in  = pend_valid_ff && !transfer;
      pend_status_in = pend_status_ff;
      pend_read_in   = pend_read_ff;
      pend_index_in  = pend_index_ff;
      rsp_valid_in   = transfer || (rsp_valid_ff && rsp_stall);
      if (accept) begin
         pend_valid_in  = 1'b1;
         pend_status_in = status;
         pend_read_in   = (bol_pkg::cmd_type'(req_cmd) == bol_pkg::CMD_READ)
                          && (status == bol_pkg::ST_OK);
         pend_index_in  = req_index;
         if (append_ok) begin
            count_in = count_ff + 1'b1;
         end else if (remove_ok) begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_status_ff <= pend_status_in;
      pend_read_ff   <= pend_read_in;
      pend_index_ff  <= pend_index_in;
      if (transfer) begin
         rsp_status_ff <= pend_status_ff;
         rsp_read_ff   <= bol_pkg::ITEM_W'(read_chain[0]);
         rsp_first_ff  <= (count_ff == '0) ? '0 : bol_pkg::ITEM_W'(value[0]);
         rsp_last_ff   <= bol_pkg::ITEM_W'(last_chain[0]);
         rsp_count_ff  <= bol_pkg::COUNT_OUT_W'(count_ff);
         rsp_empty_ff  <= (count_ff == '0);
      end
   end

   assign req_stall       = pend_valid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_read_ff;
   assign rsp_first_value = rsp_first_ff;
   assign rsp_last_value  = rsp_last_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;

endmodule
`default_nettype wire

>>> hw/rtl/bol_checker.sv
// Port-level checks for the bounded ordered list, bound onto the top level.
// Depends on bol_pkg and bounded_ordered_list_core.
`default_nettype none
module bol_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_stall,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_stall,
   input wire logic [bol_pkg::STATUS_W-1:0]       rsp_status,
   input wire logic [bol_pkg::ITEM_W-1:0]         rsp_read_value,
   input wire logic [bol_pkg::ITEM_W-1:0]         rsp_first_value,
   input wire logic [bol_pkg::ITEM_W-1:0]         rsp_last_value,
   input wire logic [bol_pkg::COUNT_OUT_W-1:0]    rsp_entry_count,
   input wire logic                               rsp_is_empty
);

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_entry_count == '0)))
      else $error("empty flag disagrees with entry count");

   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_empty) |-> (rsp_first_value == '0 && rsp_last_value == '0))
      else $error("empty list reports non-zero first or last entry");

   a_failed_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != bol_pkg::ST_OK) |-> (rsp_read_value == '0))
      else $error("failed request returns a read value");

   a_one_pending: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while another is pending");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status)
                                    && $stable(rsp_entry_count)))
      else $error("stalled response changed");

endmodule

bind bounded_ordered_list_core bol_checker u_bol_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_read_value  (rsp_read_value),
   .rsp_first_value (rsp_first_value),
   .rsp_last_value  (rsp_last_value),
   .rsp_entry_count (rsp_entry_count),
   .rsp_is_empty    (rsp_is_empty)
);
`default_nettype wire
